// ===== sv/mlrt_pkg.sv =====
package mlrt_pkg;

    // Sizes of the stored data.
    localparam int FEATURES    = 16;
    localparam int FW          = $clog2(FEATURES);
    localparam int CW          = $clog2(FEATURES + 1);
    localparam int MAX_SAMPLES = 1024;
    localparam int RW          = $clog2(MAX_SAMPLES);
    localparam int NW          = $clog2(MAX_SAMPLES + 1);
    localparam int MASK_W      = 16;

    // Fixed-point widths and constants.
    localparam int GW       = 48;
    localparam int ACC_W    = 56;
    localparam int PROD_W   = 66;
    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;

    // Sigmoid table geometry.
    localparam int SIG_DEPTH = 256;
    localparam int SIG_IW    = $clog2(SIG_DEPTH);
    localparam int SIG_HALF  = SIG_DEPTH / 2;
    localparam int SIG_SHIFT = 20 - SIG_IW;
    localparam longint SIG_H = (longint'(16) <<< 30) / SIG_DEPTH;

    // Pipeline depth from command issue to the last write.
    localparam int DRAIN_CYC = 4;

    typedef enum logic [2:0] {
        CMD_WR_FEAT  = 3'd0,
        CMD_WR_LABEL = 3'd1,
        CMD_TRAIN    = 3'd2,
        CMD_WR_TEST  = 3'd3,
        CMD_PREDICT  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_PRED   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_LR         = 3'd0,
        CFG_IL         = 3'd1,
        CFG_ITERS      = 3'd2,
        CFG_USE_BIAS   = 3'd3,
        CFG_TRAIN_MASK = 3'd4,
        CFG_TEST_MASK  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SCORE,
        OP_CLR,
        OP_GRAD,
        OP_PEN,
        OP_UPD_LO,
        OP_UPD_HI,
        OP_PSCORE,
        OP_EMIT_W,
        OP_EMIT_P
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCORE,
        ST_CLR,
        ST_GRAD,
        ST_PEN,
        ST_UPD,
        ST_DRAIN,
        ST_EMIT,
        ST_PSCORE,
        ST_PEMIT
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic [9:0]         sample_index;
        logic [3:0]         feature_index;
        logic signed [31:0] feature_value;
        logic               class_label;
        logic [10:0]        sample_count;
        logic               want_probability;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [3:0]         result_index;
        logic signed [31:0] result_value;
        logic               last_result;
    } t_out_item;

    typedef struct packed {
        logic [16:0] learning_rate;
        logic [16:0] inverse_lambda;
        logic [15:0] iteration_count;
        logic        use_bias;
        logic [15:0] train_feature_mask;
        logic [15:0] test_feature_mask;
    } t_cfg;

    // One datapath step issued by the controller.
    typedef struct packed {
        logic          load;
        t_op           op;
        logic [RW-1:0] row;
        logic [CW-1:0] feat;
        logic          last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_hold;
    } t_dp_status;

    typedef logic [16:0] t_sig_tab [SIG_DEPTH];

    // Unsigned restoring division for non-negative operands, used only while
    // the table is built.
    function automatic longint f_udiv(input longint num, input longint den);
        longint q;
        longint rem;
        int     b;
        q   = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Sigmoid table: e^-h by a truncated series, powers in Q30, rounded quotient.
    function automatic t_sig_tab f_build_sig();
        t_sig_tab tab;
        longint   h;
        longint   mag;
        longint   r;
        longint   e;
        longint   den;
        longint   s;
        int       n;
        int       a;
        h   = SIG_H;
        mag = longint'(1) <<< 30;
        r   = mag;
        for (n = 1; n < 25; n++) begin
            mag = f_udiv((mag * h) >>> 30, longint'(n));
            r   = n[0] ? r - mag : r + mag;
        end
        if (r < 0) r = 0;
        e = longint'(1) <<< 30;
        for (a = 0; a <= SIG_DEPTH; a++) begin
            den = (longint'(1) <<< 30) + e;
            s   = f_udiv((longint'(1) <<< 46) + (den >>> 1), den);
            if (SIG_HALF + a < SIG_DEPTH) tab[SIG_HALF + a] = 17'(s);
            if (a > 0 && SIG_HALF - a >= 0) tab[SIG_HALF - a] = 17'(ONE_Q16 - s);
            e = (e * r) >>> 30;
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = f_build_sig();

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [GW-1:0] f_sat48(input logic signed [63:0] v);
        if (v > 64'sh00007fffffffffff) return {1'b0, {(GW-1){1'b1}}};
        if (v < 64'shffff800000000000) return {1'b1, {(GW-1){1'b0}}};
        return v[GW-1:0];
    endfunction

endpackage

// ===== sv/mlrt_ctrl.sv =====
module mlrt_ctrl
    import mlrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in,
    input  t_cfg       i_cfg,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state        r_state, n_state;
    t_state        r_after, n_after;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_feat, n_feat;
    logic          r_half, n_half;
    logic [15:0]   r_iter, n_iter;
    logic [2:0]    r_drn, n_drn;
    logic [NW-1:0] r_n, n_n;

    logic          w_last_row;
    logic [NW-1:0] w_cnt;
    logic [15:0]   w_iter_inc;

    assign w_last_row = ({1'b0, r_row} == r_n - NW'(1));
    assign w_cnt      = (i_in.sample_count > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES)
                                                               : i_in.sample_count;
    assign w_iter_inc = r_iter + 16'd1;

    // State register and loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= ST_IDLE;
            r_row   <= '0;
            r_feat  <= '0;
            r_half  <= 1'b0;
            r_iter  <= '0;
            r_drn   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_row   <= n_row;
            r_feat  <= n_feat;
            r_half  <= n_half;
            r_iter  <= n_iter;
            r_drn   <= n_drn;
            r_n     <= n_n;
        end
    end

    // Sequencing of the training and prediction passes.
    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_row      = r_row;
        n_feat     = r_feat;
        n_half     = r_half;
        n_iter     = r_iter;
        n_drn      = r_drn;
        n_n        = r_n;
        o_in_stall = 1'b1;
        o_cmd      = '{load: 1'b0, op: OP_NONE, row: r_row, feat: r_feat, last: 1'b0};

        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                n_row      = '0;
                n_feat     = '0;
                n_half     = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_in.command)
                        CMD_TRAIN: begin
                            n_n    = w_cnt;
                            n_iter = '0;
                            if (i_cfg.iteration_count == '0) begin
                                n_state = ST_EMIT;
                            end else if (w_cnt == '0) begin
                                n_state = ST_CLR;
                            end else begin
                                n_state = ST_SCORE;
                            end
                        end
                        CMD_PREDICT: n_state = ST_PSCORE;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end

            ST_SCORE: begin
                o_cmd.op   = OP_SCORE;
                o_cmd.last = (r_feat == CW'(FEATURES - 1));
                n_feat     = r_feat + CW'(1);
                if (r_feat == CW'(FEATURES - 1)) begin
                    n_feat = '0;
                    if (w_last_row) begin
                        n_row   = '0;
                        n_state = ST_DRAIN;
                        n_after = ST_CLR;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end
            end

            ST_CLR: begin
                o_cmd.op = OP_CLR;
                n_feat   = r_feat + CW'(1);
                if (r_feat == CW'(FEATURES)) begin
                    n_feat  = '0;
                    n_state = (r_n == '0) ? ST_PEN : ST_GRAD;
                end
            end

            ST_GRAD: begin
                o_cmd.op = OP_GRAD;
                n_feat   = r_feat + CW'(1);
                if (r_feat == CW'(FEATURES)) begin
                    n_feat = '0;
                    if (w_last_row) begin
                        n_row   = '0;
                        n_state = ST_DRAIN;
                        n_after = ST_PEN;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end
            end

            ST_PEN: begin
                o_cmd.op = OP_PEN;
                n_feat   = r_feat + CW'(1);
                if (r_feat == CW'(FEATURES)) begin
                    n_feat  = '0;
                    n_state = ST_DRAIN;
                    n_after = ST_UPD;
                end
            end

            ST_UPD: begin
                o_cmd.op = r_half ? OP_UPD_HI : OP_UPD_LO;
                n_half   = !r_half;
                if (r_half) begin
                    n_feat = r_feat + CW'(1);
                    if (r_feat == CW'(FEATURES)) begin
                        n_feat  = '0;
                        n_iter  = w_iter_inc;
                        n_state = ST_DRAIN;
                        if (w_iter_inc == i_cfg.iteration_count) begin
                            n_after = ST_EMIT;
                        end else if (r_n == '0) begin
                            n_after = ST_CLR;
                        end else begin
                            n_after = ST_SCORE;
                        end
                    end
                end
            end

            ST_DRAIN: begin
                n_drn = r_drn + 3'd1;
                if (r_drn == 3'(DRAIN_CYC - 1)) begin
                    n_drn   = '0;
                    n_state = r_after;
                end
            end

            ST_EMIT: begin
                if (!i_status.out_hold) begin
                    o_cmd.op = OP_EMIT_W;
                    n_feat   = r_feat + CW'(1);
                    if (r_feat == CW'(FEATURES)) begin
                        n_feat  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_PSCORE: begin
                o_cmd.op   = OP_PSCORE;
                o_cmd.last = (r_feat == CW'(FEATURES - 1));
                n_feat     = r_feat + CW'(1);
                if (r_feat == CW'(FEATURES - 1)) begin
                    n_feat  = '0;
                    n_state = ST_DRAIN;
                    n_after = ST_PEMIT;
                end
            end

            ST_PEMIT: begin
                if (!i_status.out_hold) begin
                    o_cmd.op = OP_EMIT_P;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== sv/mlrt_dp.sv =====
module mlrt_dp
    import mlrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_in,
    input  t_cfg       i_cfg,
    output t_dp_status o_status,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data
);

    // Stored data.
    logic [31:0]          mem_x [MAX_SAMPLES * FEATURES];
    logic                 mem_l [MAX_SAMPLES];
    logic [31:0]          mem_a [MAX_SAMPLES];
    logic signed [31:0]   r_test [FEATURES];
    logic signed [31:0]   r_w [FEATURES];
    logic signed [31:0]   r_bias;
    logic signed [GW-1:0] r_gsum [FEATURES + 1];
    logic                 r_want;
    logic signed [31:0]   r_pred;

    // Pipeline registers.
    t_op                  r1_op, r2_op, r3_op;
    logic [CW-1:0]        r1_feat, r2_feat;
    logic [RW-1:0]        r1_row, r2_row, r3_row;
    logic                 r1_last, r2_last, r3_fin;
    logic signed [31:0]   r1_x, r1_tx, r1_w, r1_act;
    logic                 r1_lbl;
    logic signed [GW-1:0] r1_g;
    logic signed [PROD_W-1:0] r2_prod, r_lo;
    logic signed [32:0]   r2_err;
    logic signed [ACC_W-1:0] r_acc;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic [16:0]          w_alpha, w_il;
    logic                 w_load_feat, w_load_lbl, w_load_test, w_load_pred;

    assign w_alpha = (i_cfg.learning_rate > 17'd65536) ? 17'd65536 : i_cfg.learning_rate;
    assign w_il    = (i_cfg.inverse_lambda > 17'd65536) ? 17'd65536 : i_cfg.inverse_lambda;

    assign w_load_feat = i_cmd.load && (i_in.command == CMD_WR_FEAT);
    assign w_load_lbl  = i_cmd.load && (i_in.command == CMD_WR_LABEL);
    assign w_load_test = i_cmd.load && (i_in.command == CMD_WR_TEST);
    assign w_load_pred = i_cmd.load && (i_in.command == CMD_PREDICT);

    // Feature memory: written by loads, read one element per step.
    always_ff @(posedge i_clk) begin
        if (w_load_feat) begin
            mem_x[{i_in.sample_index, i_in.feature_index}] <= i_in.feature_value;
        end
        r1_x <= mem_x[{i_cmd.row, i_cmd.feat[FW-1:0]}];
    end

    // Label memory.
    always_ff @(posedge i_clk) begin
        if (w_load_lbl) begin
            mem_l[i_in.sample_index] <= i_in.class_label;
        end
        r1_lbl <= mem_l[i_cmd.row];
    end

    // Test row and predict mode.
    always_ff @(posedge i_clk) begin
        if (w_load_test) begin
            r_test[i_in.feature_index] <= i_in.feature_value;
        end
        if (w_load_pred) begin
            r_want <= i_in.want_probability;
        end
    end

    // Stage 1: operand fetch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_op <= OP_NONE;
        end else begin
            r1_op <= (i_cmd.op == OP_EMIT_W || i_cmd.op == OP_EMIT_P) ? OP_NONE : i_cmd.op;
        end
        r1_feat <= i_cmd.feat;
        r1_row  <= i_cmd.row;
        r1_last <= i_cmd.last;
        r1_tx   <= r_test[i_cmd.feat[FW-1:0]];
        r1_w    <= (i_cmd.feat == CW'(FEATURES)) ? r_bias : r_w[i_cmd.feat[FW-1:0]];
        r1_g    <= r_gsum[i_cmd.feat];
    end

    // Stage 2: operand select and the shared multiplier.
    logic               w_en;
    logic signed [31:0] w_xs;
    logic signed [32:0] w_err, w_a, w_b;

    always_comb begin
        w_en  = (r1_feat >= CW'(FEATURES)) ||
                ((r1_op == OP_PSCORE) ? i_cfg.test_feature_mask[r1_feat[FW-1:0]]
                                      : i_cfg.train_feature_mask[r1_feat[FW-1:0]]);
        w_xs  = w_en ? ((r1_op == OP_PSCORE) ? r1_tx : r1_x) : 32'sd0;
        w_err = $signed({r1_act[31], r1_act}) - (r1_lbl ? 33'sd65536 : 33'sd0);
        w_a   = '0;
        w_b   = '0;
        unique case (r1_op)
            OP_SCORE, OP_PSCORE: begin
                w_a = {w_xs[31], w_xs};
                w_b = {r1_w[31], r1_w};
            end
            OP_GRAD: begin
                w_a = {w_xs[31], w_xs};
                w_b = w_err;
            end
            OP_PEN: begin
                w_a = {r1_w[31], r1_w};
                w_b = $signed({16'd0, w_il});
            end
            OP_UPD_LO: begin
                w_a = $signed({16'd0, w_alpha});
                w_b = $signed({9'd0, r1_g[23:0]});
            end
            OP_UPD_HI: begin
                w_a = $signed({16'd0, w_alpha});
                w_b = $signed({{9{r1_g[GW-1]}}, r1_g[GW-1:24]});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_op <= OP_NONE;
        end else begin
            r2_op <= r1_op;
        end
        r2_prod <= w_a * w_b;
        r2_err  <= w_err;
        r2_feat <= r1_feat;
        r2_row  <= r1_row;
        r2_last <= r1_last;
    end

    // Stage 3: accumulate and update.
    logic signed [49:0]       w_term, w_step;
    logic signed [PROD_W-1:0] w_total;
    logic signed [31:0]       w_cur, w_new;

    always_comb begin
        w_term  = r2_prod[65:16];
        w_total = $signed({r2_prod[41:0], 24'd0}) + r_lo;
        w_step  = w_total[65:16];
        w_cur   = (r2_feat == CW'(FEATURES)) ? r_bias : r_w[r2_feat[FW-1:0]];
        w_new   = f_sat32(64'(w_cur) - 64'(w_step));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_fin <= 1'b0;
        end else begin
            r3_fin <= (r2_op == OP_SCORE || r2_op == OP_PSCORE) && r2_last;
        end
        r3_op  <= r2_op;
        r3_row <= r2_row;
        if (r2_op == OP_SCORE || r2_op == OP_PSCORE) begin
            r_acc <= ((r2_feat == '0) ? ACC_W'(0) : r_acc) + ACC_W'(w_term);
        end
        if (r2_op == OP_UPD_LO) begin
            r_lo <= r2_prod;
        end
    end

    // Gradient sums.
    always_ff @(posedge i_clk) begin
        unique case (r2_op)
            OP_CLR:  r_gsum[r2_feat] <= '0;
            OP_GRAD: r_gsum[r2_feat] <= r_gsum[r2_feat] +
                         ((r2_feat == CW'(FEATURES)) ? GW'(r2_err) : w_term[GW-1:0]);
            OP_PEN:  r_gsum[r2_feat] <= f_sat48(64'(r_gsum[r2_feat]) + 64'(w_term));
            default: ;
        endcase
    end

    // Weights and bias.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FEATURES; k++) begin
                r_w[k] <= '0;
            end
            r_bias <= '0;
        end else if (r2_op == OP_UPD_HI) begin
            if (r2_feat == CW'(FEATURES)) begin
                if (i_cfg.use_bias) r_bias <= w_new;
            end else begin
                r_w[r2_feat[FW-1:0]] <= w_new;
            end
        end
    end

    // Stage 4: bias, saturation and sigmoid lookup.
    logic signed [31:0]       w_score;
    logic signed [SIG_IW+12:0] w_ix;
    logic [SIG_IW-1:0]        w_idx;
    logic [16:0]              w_sig;

    always_comb begin
        w_score = f_sat32(64'(r_acc) + (i_cfg.use_bias ? 64'(r_bias) : 64'sd0));
        w_ix    = (SIG_IW+13)'(w_score >>> SIG_SHIFT) + (SIG_IW+13)'(SIG_HALF);
        if (w_ix < 0) begin
            w_idx = '0;
        end else if (w_ix > (SIG_IW+13)'(SIG_DEPTH - 1)) begin
            w_idx = SIG_IW'(SIG_DEPTH - 1);
        end else begin
            w_idx = w_ix[SIG_IW-1:0];
        end
        w_sig = SIG_TABLE[w_idx];
    end

    // Activation memory: written at the end of a row score, read by the gradient pass.
    always_ff @(posedge i_clk) begin
        if (r3_fin && r3_op == OP_SCORE) begin
            mem_a[r3_row] <= {15'd0, w_sig};
        end
        r1_act <= mem_a[i_cmd.row];
    end

    always_ff @(posedge i_clk) begin
        if (r3_fin && r3_op == OP_PSCORE) begin
            if (r_want) begin
                r_pred <= {15'd0, w_sig};
            end else begin
                r_pred <= (w_sig > 17'(HALF_Q16)) ? 32'(ONE_Q16) : 32'sd0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT_W || i_cmd.op == OP_EMIT_P) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT_W) begin
            if (i_cmd.feat == CW'(FEATURES)) begin
                r_out <= '{result_kind: KIND_BIAS, result_index: 4'd0,
                           result_value: r_bias, last_result: 1'b1};
            end else begin
                r_out <= '{result_kind: KIND_WEIGHT, result_index: i_cmd.feat[FW-1:0],
                           result_value: r_w[i_cmd.feat[FW-1:0]], last_result: 1'b0};
            end
        end else if (i_cmd.op == OP_EMIT_P) begin
            r_out <= '{result_kind: KIND_PRED, result_index: 4'd0,
                       result_value: r_pred, last_result: 1'b1};
        end
    end

    assign o_status.out_hold = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ===== sv/masked_logistic_regression_trainer.sv =====
// Masked logistic-regression trainer, signed Q16.16.
// Input channel: i_in_valid / o_in_stall carry one command beat in i_in_data.
// Feature, label and test-row writes do not stall the input and return nothing.
// Train runs iteration_count full-batch passes over sample_count rows, then
// emits FEATURES weight beats and one bias beat (last_result set on the bias).
// Predict scores the test row and emits one beat with last_result set.
// Output channel: o_out_valid / i_out_stall through a single output register;
// while the receiver stalls, the beat holds and the block waits to emit more.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once.
// The datapath does at most one feature-memory read and one multiply per
// cycle; a train command ends with the weight and bias emit beats, which
// wait out receiver stalls. Predict emits its beat once the test row is
// scored and the pipeline has drained. The input stalls while a command runs.
// Synchronous reset clears weights, bias, configuration to defaults and the
// control state; the sample memories keep their contents.
module masked_logistic_regression_trainer
    import mlrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{learning_rate: 17'd655, inverse_lambda: 17'd65536,
                       iteration_count: 16'd100, use_bias: 1'b1,
                       train_feature_mask: 16'hffff, test_feature_mask: 16'hffff};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LR:         r_cfg.learning_rate      <= i_cfg_data;
                CFG_IL:         r_cfg.inverse_lambda     <= i_cfg_data;
                CFG_ITERS:      r_cfg.iteration_count    <= i_cfg_data[15:0];
                CFG_USE_BIAS:   r_cfg.use_bias           <= i_cfg_data[0];
                CFG_TRAIN_MASK: r_cfg.train_feature_mask <= i_cfg_data[15:0];
                CFG_TEST_MASK:  r_cfg.test_feature_mask  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mlrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in_data),
        .i_cfg      (r_cfg),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    mlrt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in_data),
        .i_cfg       (r_cfg),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/mlrt_chk.sv =====
module mlrt_chk
    import mlrt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A stalled output beat stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped under stall");

    // The bias beat closes a train command.
    a_bias_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_BIAS |-> o_out_data.last_result)
        else $error("bias beat without last flag");

    // A prediction is a single closing beat at index zero.
    a_pred_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_PRED
        |-> o_out_data.last_result && o_out_data.result_index == 4'd0)
        else $error("malformed prediction beat");

    // Write commands never block the input channel.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        (i_in_data.command == CMD_WR_FEAT || i_in_data.command == CMD_WR_LABEL ||
         i_in_data.command == CMD_WR_TEST) |=> !o_in_stall)
        else $error("write command stalled the input");

endmodule

bind masked_logistic_regression_trainer mlrt_chk u_mlrt_chk (.*);

// ===== verif/tb.sv =====
module tb;
    import mlrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYC = 4 * DRAIN_CYC + 16;
    localparam int LOAD_ROWS  = 4;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [16:0] i_cfg_data = '0;

    masked_logistic_regression_trainer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the trainer state.
    longint    feat_mem [MAX_SAMPLES][FEATURES];
    bit        label_mem [MAX_SAMPLES];
    longint    test_vec [FEATURES];
    longint    weight_q [FEATURES];
    longint    bias_q;
    longint    sig_lut [SIG_DEPTH];
    t_cfg      cfg_q;

    t_out_item pending_results [$];
    int        errors = 0;
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;

    function automatic longint sat_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Table sigmoid: e^-h from a truncated series, then powers in Q30.
    task automatic build_sigmoid_lut();
        longint h;
        longint mag;
        longint r;
        longint e;
        longint den;
        longint s;
        h   = (longint'(16) <<< 30) / SIG_DEPTH;
        mag = longint'(1) <<< 30;
        r   = mag;
        for (int n = 1; n < 25; n++) begin
            mag = ((mag * h) >>> 30) / n;
            if (n % 2 == 1) r = r - mag;
            else r = r + mag;
        end
        if (r < 0) r = 0;
        e = longint'(1) <<< 30;
        for (int a = 0; a <= SIG_DEPTH; a++) begin
            den = (longint'(1) <<< 30) + e;
            s   = ((longint'(1) <<< 46) + den / 2) / den;
            if (SIG_HALF + a < SIG_DEPTH) sig_lut[SIG_HALF + a] = s;
            if (a > 0 && SIG_HALF - a >= 0) sig_lut[SIG_HALF - a] = ONE_Q16 - s;
            e = (e * r) >>> 30;
        end
    endtask

    function automatic longint sigmoid_of(longint score);
        longint idx;
        idx = ((score * SIG_DEPTH) >>> 20) + SIG_HALF;
        if (idx < 0) idx = 0;
        if (idx > SIG_DEPTH - 1) idx = SIG_DEPTH - 1;
        return sig_lut[idx];
    endfunction

    function automatic bit feat_on(logic [15:0] mask, int d);
        return d >= MASK_W ? 1'b1 : mask[d];
    endfunction

    function automatic longint row_score(longint row [FEATURES], logic [15:0] mask);
        longint acc;
        acc = 0;
        for (int d = 0; d < FEATURES; d++)
            if (feat_on(mask, d)) acc += (row[d] * weight_q[d]) >>> 16;
        if (cfg_q.use_bias) acc += bias_q;
        return sat_to(acc, 32);
    endfunction

    task automatic push_result(t_kind kind, int idx, longint value, bit last);
        t_out_item r;
        r.result_kind  = kind;
        r.result_index = 4'(idx);
        r.result_value = 32'(value);
        r.last_result  = last;
        pending_results.push_back(r);
    endtask

    // Full-batch gradient descent, then every weight and the bias.
    task automatic run_training(int count);
        longint n;
        longint alpha;
        longint il;
        longint err;
        longint grad [FEATURES + 1];
        longint acts [];
        longint row [FEATURES];
        n     = count > MAX_SAMPLES ? MAX_SAMPLES : count;
        alpha = cfg_q.learning_rate > ONE_Q16 ? ONE_Q16 : cfg_q.learning_rate;
        il    = cfg_q.inverse_lambda > ONE_Q16 ? ONE_Q16 : cfg_q.inverse_lambda;
        acts  = new[n + 1];
        for (int it = 0; it < cfg_q.iteration_count; it++) begin
            for (int i = 0; i < n; i++) begin
                row = feat_mem[i];
                acts[i] = sigmoid_of(row_score(row, cfg_q.train_feature_mask));
            end
            for (int d = 0; d <= FEATURES; d++) grad[d] = 0;
            for (int i = 0; i < n; i++) begin
                err = acts[i] - (label_mem[i] ? ONE_Q16 : 0);
                for (int d = 0; d < FEATURES; d++)
                    if (feat_on(cfg_q.train_feature_mask, d))
                        grad[d] += (feat_mem[i][d] * err) >>> 16;
                grad[FEATURES] += err;
            end
            for (int d = 0; d < FEATURES; d++)
                grad[d] = sat_to(grad[d] + ((weight_q[d] * il) >>> 16), GW);
            grad[FEATURES] = sat_to(grad[FEATURES] + ((bias_q * il) >>> 16), GW);
            for (int d = 0; d < FEATURES; d++)
                weight_q[d] = sat_to(weight_q[d] - ((alpha * grad[d]) >>> 16), 32);
            if (cfg_q.use_bias)
                bias_q = sat_to(bias_q - ((alpha * grad[FEATURES]) >>> 16), 32);
        end
        for (int d = 0; d < FEATURES; d++) push_result(KIND_WEIGHT, d, weight_q[d], 1'b0);
        push_result(KIND_BIAS, 0, bias_q, 1'b1);
    endtask

    // Update the mirror for one accepted command and queue its results.
    task automatic apply_command(t_in_item it);
        longint p;
        case (it.command)
            CMD_WR_FEAT:  feat_mem[it.sample_index][it.feature_index] = it.feature_value;
            CMD_WR_LABEL: label_mem[it.sample_index] = it.class_label;
            CMD_TRAIN:    run_training(it.sample_count);
            CMD_WR_TEST:  test_vec[it.feature_index] = it.feature_value;
            CMD_PREDICT: begin
                p = sigmoid_of(row_score(test_vec, cfg_q.test_feature_mask));
                if (!it.want_probability) p = p > HALF_Q16 ? ONE_Q16 : 0;
                push_result(KIND_PRED, 0, p, 1'b1);
            end
            default: ;
        endcase
    endtask

    // Drive one command beat and wait until it is taken.
    task automatic send_item(t_in_item it);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_command(it);
    endtask

    // Wait until every result is in and the pipeline has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [16:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_LR:         cfg_q.learning_rate      = value;
            CFG_IL:         cfg_q.inverse_lambda     = value;
            CFG_ITERS:      cfg_q.iteration_count    = value[15:0];
            CFG_USE_BIAS:   cfg_q.use_bias           = value[0];
            CFG_TRAIN_MASK: cfg_q.train_feature_mask = value[15:0];
            CFG_TEST_MASK:  cfg_q.test_feature_mask  = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Mostly small values so training stays in range, sometimes anything.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return 32'h0;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic t_in_item make_cmd(logic [2:0] cmd);
        t_in_item it;
        it = '0;
        it.command          = cmd;
        it.sample_index     = 10'($urandom());
        it.feature_index    = 4'($urandom());
        it.feature_value    = pick_value();
        it.class_label      = 1'($urandom());
        it.sample_count     = 11'($urandom_range(0, 12));
        it.want_probability = 1'($urandom());
        return it;
    endfunction

    task automatic train_cmd(int count);
        t_in_item it;
        it = make_cmd(CMD_TRAIN);
        it.sample_count = 11'(count);
        send_item(it);
    endtask

    task automatic predict_cmd(bit want_prob);
        t_in_item it;
        it = make_cmd(CMD_PREDICT);
        it.want_probability = want_prob;
        send_item(it);
    endtask

    // Every training row that a train command reads, its label and the test
    // row get a value first.
    task automatic test_load_all();
        t_in_item it;
        for (int s = 0; s < LOAD_ROWS; s++) begin
            for (int d = 0; d < FEATURES; d++) begin
                it = make_cmd(CMD_WR_FEAT);
                it.sample_index  = 10'(s);
                it.feature_index = 4'(d);
                send_item(it);
            end
            it = make_cmd(CMD_WR_LABEL);
            it.sample_index = 10'(s);
            send_item(it);
        end
        for (int d = 0; d < FEATURES; d++) begin
            it = make_cmd(CMD_WR_TEST);
            it.feature_index = 4'(d);
            send_item(it);
        end
    endtask

    task automatic test_directed();
        t_in_item it;
        // Untrained model: probability exactly one half, class zero.
        predict_cmd(1'b1);
        predict_cmd(1'b0);
        // Unused commands return nothing.
        for (int k = 1; k <= 3; k++) send_item(make_cmd(3'(CMD_PREDICT) + 3'(k)));
        // Reset settings, two rows.
        train_cmd(2);
        predict_cmd(1'b1);
        // Zero iterations only emits; zero rows trains on the penalty alone.
        write_reg(CFG_ITERS, 17'd0);
        train_cmd(5);
        write_reg(CFG_ITERS, 17'd1);
        train_cmd(0);
        // Oversized rates, bias off, all features and then no features enabled.
        write_reg(CFG_LR, 17'h1ffff);
        write_reg(CFG_IL, 17'h1ffff);
        write_reg(CFG_USE_BIAS, 17'd0);
        write_reg(CFG_TRAIN_MASK, 17'h1ffff);
        train_cmd(3);
        write_reg(CFG_TRAIN_MASK, 17'd0);
        write_reg(CFG_TEST_MASK, 17'd0);
        train_cmd(4);
        predict_cmd(1'b0);
        // Zero rate and zero penalty leave the model alone.
        write_reg(CFG_LR, 17'd0);
        write_reg(CFG_IL, 17'd0);
        write_reg(CFG_USE_BIAS, 17'd1);
        train_cmd(2);
        write_reg(CFG_LR, 17'd65536);
        write_reg(CFG_IL, 17'd65536);
        write_reg(CFG_TEST_MASK, 17'h1ffff);
        write_reg(CFG_TRAIN_MASK, 17'h0ffff);
        it = make_cmd(CMD_WR_TEST);
        it.feature_value = 32'h7fff_ffff;
        send_item(it);
        predict_cmd(1'b1);
        predict_cmd(1'b0);
    endtask

    // A count beyond the row limit, with no iteration, only emits the model.
    task automatic test_full_batch();
        write_reg(CFG_LR, 17'd655);
        write_reg(CFG_IL, 17'd65536);
        write_reg(CFG_ITERS, 17'd0);
        train_cmd(2047);
        write_reg(CFG_ITERS, 17'd1);
        predict_cmd(1'b1);
    endtask

    task automatic test_random(int items);
        int r;
        write_reg(CFG_LR, 17'($urandom_range(0, 65536)));
        write_reg(CFG_IL, 17'($urandom_range(0, 65536)));
        write_reg(CFG_ITERS, 17'($urandom_range(1, 3)));
        write_reg(CFG_USE_BIAS, 17'($urandom_range(0, 1)));
        write_reg(CFG_TRAIN_MASK, 17'($urandom_range(0, 65535)));
        write_reg(CFG_TEST_MASK, 17'($urandom_range(0, 65535)));
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) send_item(make_cmd(CMD_WR_FEAT));
            else if (r < 40) send_item(make_cmd(CMD_WR_LABEL));
            else if (r < 52) send_item(make_cmd(CMD_WR_TEST));
            else if (r < 70) train_cmd($urandom_range(0, LOAD_ROWS));
            else if (r < 95) predict_cmd(1'($urandom()));
            else send_item(make_cmd(3'(CMD_PREDICT) + 3'($urandom_range(1, 3))));
        end
    endtask

    // Output side: random stall, and each taken beat against the oldest expectation.
    task automatic report_mismatch(string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result_kind !== want.result_kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                        o_out_data.result_kind, want.result_kind));
                if (o_out_data.result_index !== want.result_index)
                    report_mismatch($sformatf("index %0d, want %0d",
                        o_out_data.result_index, want.result_index));
                if (o_out_data.result_value !== want.result_value)
                    report_mismatch($sformatf("value %h, want %h",
                        o_out_data.result_value, want.result_value));
                if (o_out_data.last_result !== want.last_result)
                    report_mismatch($sformatf("last %0b, want %0b",
                        o_out_data.last_result, want.last_result));
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    initial begin
        cfg_q = '{learning_rate: 17'd655, inverse_lambda: 17'd65536,
                  iteration_count: 16'd100, use_bias: 1'b1,
                  train_feature_mask: 16'hffff, test_feature_mask: 16'hffff};
        for (int d = 0; d < FEATURES; d++) begin
            weight_q[d] = 0;
            test_vec[d] = 0;
        end
        bias_q = 0;
        build_sigmoid_lut();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 13;
        rcv_idle_pct = 77;
        test_load_all();
        test_directed();
        test_random(16);
        snd_idle_pct = 77;
        rcv_idle_pct = 13;
        test_full_batch();
        test_random(16);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(16);

        settle();
        if (pending_results.size() != 0) report_mismatch("expected results left over");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mlrt_pkg.sv
sv/mlrt_ctrl.sv
sv/mlrt_dp.sv
sv/masked_logistic_regression_trainer.sv
sv/mlrt_chk.sv
verif/tb.sv
